### hw/rtl/window_hit_test_move_to_front_macros.svh
// Assertion macros for the window hit test block.
`ifndef WINDOW_HIT_TEST_MOVE_TO_FRONT_MACROS_SVH
`define WINDOW_HIT_TEST_MOVE_TO_FRONT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WHTF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WHTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/whtf_pkg.sv
// Shared constants for the window hit test block.
package whtf_pkg;

  localparam int unsigned NUM_WINDOWS_DEF = 16;
  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned ID_BITS         = 5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CLICK = 1'b1;

endpackage

### hw/rtl/whtf_if.sv
// Input and result channel interfaces of the window hit test block.
interface whtf_in_if #(
  parameter int unsigned COORD_BITS = whtf_pkg::COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [COORD_BITS-1:0] x_left;
  logic [COORD_BITS-1:0] y_bottom;
  logic [COORD_BITS-1:0] x_right;
  logic [COORD_BITS-1:0] y_top;

  modport source (output valid, cmd, x_left, y_bottom, x_right, y_top, input ready);
  modport sink   (input valid, cmd, x_left, y_bottom, x_right, y_top, output ready);
endinterface

interface whtf_out_if ();
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [whtf_pkg::ID_BITS-1:0] window_id;

  modport source (output valid, hit, window_id, input ready);
  modport sink   (input valid, hit, window_id, output ready);
endinterface

### hw/rtl/window_hit_test_move_to_front.sv
// Window stack with click hit test and move-to-front, run by a small sequencer.
//
//  channel | dir | beat contents                                | handshake
//  in_i    | in  | cmd, x_left, y_bottom, x_right, y_top        | valid/ready
//  out_o   | out | hit, window_id (one beat per click, none/load) | valid/ready
//
// A click tests one stack position at a time through the single compare unit
// and memory read ports, then moves a hit to the top by a read and a write per
// position above it; a miss is reported once every stored position is tested.
// A load shifts the stack the same way to put the new window on top; a load to
// a full store is dropped. in_i is ready only in the idle state. A result waits
// in the output register while the next item is taken; a finished click holds
// until that register is free. Reset empties the stack at once.
module window_hit_test_move_to_front #(
  parameter int unsigned NUM_WINDOWS = whtf_pkg::NUM_WINDOWS_DEF,
  parameter int unsigned COORD_BITS  = whtf_pkg::COORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  whtf_in_if.sink    in_i,
  whtf_out_if.source out_o
);
  import whtf_pkg::*;

  localparam int unsigned IdxBits  = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
  localparam int unsigned CntBits  = $clog2(NUM_WINDOWS + 1);
  localparam int unsigned RectBits = 4 * COORD_BITS;
  localparam int unsigned IdWide   = IdxBits + ID_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_SLOT  = 7'b0000100,
    S_TEST  = 7'b0001000,
    S_SH_RD = 7'b0010000,
    S_SH_WR = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [CntBits-1:0]   count_q, count_d;
  logic [CntBits-1:0]   pos_q, pos_d;
  logic [CntBits-1:0]   depth_q, depth_d;
  logic [IdxBits-1:0]   slot_q, slot_d;
  logic                 click_q, click_d;
  logic                 hit_q, hit_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_hit_q, out_hit_d;
  logic [ID_BITS-1:0]   out_id_q, out_id_d;
  logic [COORD_BITS-1:0] px_q, py_q;

  logic                 accept;
  logic                 full;
  logic                 rect_we;
  logic [RectBits-1:0]  rect_rdata;
  logic                 ord_we;
  logic [IdxBits-1:0]   ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic [CntBits-1:0]   depth_m1;
  logic                 unit_hit;
  logic [IdWide-1:0]    id_wide;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CntBits'(NUM_WINDOWS));
  assign depth_m1   = depth_q - CntBits'(1);
  assign rect_we    = accept && (in_i.cmd == CMD_LOAD) && !full;
  assign id_wide    = IdWide'(slot_q) + IdWide'(1);

  whtf_store #(
    .NUM_WINDOWS (NUM_WINDOWS),
    .COORD_BITS  (COORD_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rect_we_i    (rect_we),
    .rect_waddr_i (count_q[IdxBits-1:0]),
    .rect_wdata_i ({in_i.x_left, in_i.y_bottom, in_i.x_right, in_i.y_top}),
    .rect_raddr_i (ord_rdata),
    .rect_rdata_o (rect_rdata),
    .ord_we_i     (ord_we),
    .ord_waddr_i  (ord_waddr),
    .ord_wdata_i  (ord_wdata),
    .ord_raddr_i  (ord_raddr),
    .ord_rdata_o  (ord_rdata)
  );

  whtf_hit_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_hit (
    .rect_i (rect_rdata),
    .x_i    (px_q),
    .y_i    (py_q),
    .hit_o  (unit_hit)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    depth_d     = depth_q;
    slot_d      = slot_q;
    click_d     = click_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_hit_d   = out_hit_q;
    out_id_d    = out_id_q;
    ord_we      = 1'b0;
    ord_waddr   = depth_q[IdxBits-1:0];
    ord_wdata   = ord_rdata;
    ord_raddr   = pos_q[IdxBits-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.cmd == CMD_CLICK) begin
            click_d = 1'b1;
            pos_d   = '0;
            state_d = S_FIND;
          end else if (!full) begin
            // New window goes on top; everything below shifts down one.
            click_d = 1'b0;
            slot_d  = count_q[IdxBits-1:0];
            depth_d = count_q;
            count_d = count_q + CntBits'(1);
            state_d = S_SH_RD;
          end
        end
      end
      S_FIND: begin
        if (pos_q == count_q) begin
          hit_d   = 1'b0;
          state_d = S_RESP;
        end else begin
          state_d = S_SLOT;
        end
      end
      S_SLOT: begin
        // Order data is the slot; its rectangle read is issued by the store.
        slot_d  = ord_rdata;
        state_d = S_TEST;
      end
      S_TEST: begin
        if (unit_hit) begin
          hit_d   = 1'b1;
          depth_d = pos_q;
          state_d = S_SH_RD;
        end else begin
          pos_d   = pos_q + CntBits'(1);
          state_d = S_FIND;
        end
      end
      S_SH_RD: begin
        if (depth_q == '0) begin
          ord_we    = 1'b1;
          ord_waddr = '0;
          ord_wdata = slot_q;
          state_d   = click_q ? S_RESP : S_IDLE;
        end else begin
          ord_raddr = depth_m1[IdxBits-1:0];
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ord_we  = 1'b1;
        depth_d = depth_m1;
        state_d = S_SH_RD;
      end
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_id_d    = hit_q ? id_wide[ID_BITS-1:0] : '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    depth_q   <= depth_d;
    slot_q    <= slot_d;
    click_q   <= click_d;
    hit_q     <= hit_d;
    out_hit_q <= out_hit_d;
    out_id_q  <= out_id_d;
    if (accept) begin
      px_q <= in_i.x_left;
      py_q <= in_i.y_bottom;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.hit       = out_hit_q;
  assign out_o.window_id = out_id_q;

endmodule

### hw/rtl/whtf_store.sv
// Rectangle memory and stack-order memory, one write and one registered read each.
module whtf_store #(
  parameter int unsigned NUM_WINDOWS = whtf_pkg::NUM_WINDOWS_DEF,
  parameter int unsigned COORD_BITS  = whtf_pkg::COORD_BITS_DEF,
  localparam int unsigned IdxBits    = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1,
  localparam int unsigned RectBits   = 4 * COORD_BITS
) (
  input  logic                clk_i,
  input  logic                rect_we_i,
  input  logic [IdxBits-1:0]  rect_waddr_i,
  input  logic [RectBits-1:0] rect_wdata_i,
  input  logic [IdxBits-1:0]  rect_raddr_i,
  output logic [RectBits-1:0] rect_rdata_o,
  input  logic                ord_we_i,
  input  logic [IdxBits-1:0]  ord_waddr_i,
  input  logic [IdxBits-1:0]  ord_wdata_i,
  input  logic [IdxBits-1:0]  ord_raddr_i,
  output logic [IdxBits-1:0]  ord_rdata_o
);

  logic [RectBits-1:0] rect_mem [NUM_WINDOWS];
  logic [IdxBits-1:0]  ord_mem  [NUM_WINDOWS];

  always_ff @(posedge clk_i) begin
    if (rect_we_i) begin
      rect_mem[rect_waddr_i] <= rect_wdata_i;
    end
    rect_rdata_o <= rect_mem[rect_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we_i) begin
      ord_mem[ord_waddr_i] <= ord_wdata_i;
    end
    ord_rdata_o <= ord_mem[ord_raddr_i];
  end

endmodule

### hw/rtl/whtf_hit_unit.sv
// Shared point-in-rectangle compare, bounds inclusive.
module whtf_hit_unit #(
  parameter int unsigned COORD_BITS = whtf_pkg::COORD_BITS_DEF,
  localparam int unsigned RectBits  = 4 * COORD_BITS
) (
  input  logic [RectBits-1:0]   rect_i,
  input  logic [COORD_BITS-1:0] x_i,
  input  logic [COORD_BITS-1:0] y_i,
  output logic                  hit_o
);

  logic [COORD_BITS-1:0] left, bottom, right, top;

  // Packed as {left, bottom, right, top}.
  assign left   = rect_i[4*COORD_BITS-1:3*COORD_BITS];
  assign bottom = rect_i[3*COORD_BITS-1:2*COORD_BITS];
  assign right  = rect_i[2*COORD_BITS-1:COORD_BITS];
  assign top    = rect_i[COORD_BITS-1:0];

  assign hit_o = (left <= x_i) && (x_i <= right) && (bottom <= y_i) && (y_i <= top);

endmodule

### hw/rtl/whtf_checker.sv
// Port-level checks on the window hit test block, bound to its top level.
`include "window_hit_test_move_to_front_macros.svh"

module whtf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_cmd_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_hit_i,
  input logic [whtf_pkg::ID_BITS-1:0] out_window_id_i
);
  import whtf_pkg::*;

  // Hold a stalled result beat.
  `WHTF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_hit_i) && $stable(out_window_id_i))
  // A miss reports id zero.
  `WHTF_ASSERT_NOW(a_miss_id_zero, clk_i, rst_ni, out_valid_i && !out_hit_i, out_window_id_i == '0)
  // A click keeps the input side busy on the next cycle.
  `WHTF_ASSERT_NEXT(a_click_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_cmd_i == CMD_CLICK, !in_ready_i)
  // A new result comes only out of a busy cycle.
  `WHTF_ASSERT_NOW(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind window_hit_test_move_to_front whtf_checker u_whtf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_cmd_i        (in_i.cmd),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_hit_i       (out_o.hit),
  .out_window_id_i (out_o.window_id)
);
